// File: sv/biquad_iir_section_unit_defines.svh
// Assertion macros shared by the biquad section RTL.
`ifndef BIQUAD_IIR_SECTION_UNIT_DEFINES_SVH
`define BIQUAD_IIR_SECTION_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bq_pkg.sv
// Package: constants, codes and control types of the biquad section.
package bq_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;
  localparam int COEF_BITS          = 32;
  localparam int STATE_BITS         = 56;
  localparam int NUM_COEFS          = 5;
  localparam int CFG_IDX_W          = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_idx_t;

  typedef enum logic [1:0] {
    ACC_OUT_SUM,
    ACC_S1_INIT,
    ACC_SUB,
    ACC_LOAD
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MB0,
    ST_MB1,
    ST_Y,
    ST_MA1,
    ST_S1,
    ST_SAV1,
    ST_S2,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic      in_ready;
    logic      load;
    coef_idx_t coef_sel;
    logic      use_y;
    logic      acc_en;
    acc_op_t   acc_op;
    logic      y_we;
    logic      s1_we;
    logic      s2_we;
    logic      out_we;
  } bq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } bq_sts_t;

endpackage

// File: sv/bq_in_if.sv
// Input request channel: sample and clear flag with valid/ready.
interface bq_in_if import bq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          clear_state;

  modport source (output valid, output sample_in, output clear_state, input ready);
  modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface

// File: sv/bq_out_if.sv
// Result request channel: filtered sample and clip flag with valid/ready.
interface bq_out_if import bq_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// File: sv/bq_ctrl.sv
// Controller: sequences the shared multiply-accumulate over one request.
`include "biquad_iir_section_unit_defines.svh"

module bq_ctrl import bq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  bq_sts_t sts,
  output bq_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign take = (state_r == ST_IDLE) || ((state_r == ST_OUT) && sts.out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = ST_MB0;
        end
      end
      ST_MB0:  state_nxt = ST_MB1;
      ST_MB1:  state_nxt = ST_Y;
      ST_Y:    state_nxt = ST_MA1;
      ST_MA1:  state_nxt = ST_S1;
      ST_S1:   state_nxt = ST_SAV1;
      ST_SAV1: state_nxt = ST_S2;
      ST_S2:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.in_valid ? ST_MB0 : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.coef_sel = COEF_B0;
    cmd.acc_op   = ACC_LOAD;
    cmd.in_ready = take;
    cmd.load     = take && sts.in_valid;
    case (state_r)
      ST_IDLE: begin
      end
      ST_MB0: begin
        cmd.coef_sel = COEF_B0;
      end
      ST_MB1: begin
        cmd.coef_sel = COEF_B1;
        cmd.acc_en   = 1'b1;
        cmd.acc_op   = ACC_OUT_SUM;
      end
      ST_Y: begin
        cmd.y_we   = 1'b1;
        cmd.acc_en = 1'b1;
        cmd.acc_op = ACC_S1_INIT;
      end
      ST_MA1: begin
        cmd.coef_sel = COEF_A1;
        cmd.use_y    = 1'b1;
      end
      ST_S1: begin
        cmd.coef_sel = COEF_B2;
        cmd.acc_en   = 1'b1;
        cmd.acc_op   = ACC_SUB;
      end
      ST_SAV1: begin
        cmd.coef_sel = COEF_A2;
        cmd.use_y    = 1'b1;
        cmd.s1_we    = 1'b1;
        cmd.acc_en   = 1'b1;
        cmd.acc_op   = ACC_LOAD;
      end
      ST_S2: begin
        cmd.acc_en = 1'b1;
        cmd.acc_op = ACC_SUB;
      end
      ST_OUT: begin
        cmd.s2_we  = sts.out_free;
        cmd.out_we = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  `BQ_ASSERT_IMP(a_idle_quiet, state_r == ST_IDLE, !(cmd.y_we || cmd.s1_we || cmd.s2_we || cmd.out_we), "write while idle")
  `BQ_ASSERT_NXT(a_load_starts, cmd.load, state_r == ST_MB0, "request did not start sequence")
  `BQ_ASSERT_IMP(a_ready_when_free, (state_r == ST_OUT) && sts.out_free, cmd.in_ready, "ready dropped at result hand-off")

endmodule

// File: sv/bq_datapath.sv
// Datapath: coefficients, shared multiplier, accumulator, states, result register.
`include "biquad_iir_section_unit_defines.svh"

module bq_datapath import bq_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_BITS-1:0]  cfg_data,
  bq_in_if.sink                 in_req,
  bq_out_if.source              out_res,
  input  bq_cmd_t               cmd,
  output bq_sts_t               sts
);

  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W  = ((PROD_W > STATE_BITS) ? PROD_W : STATE_BITS) + 2;
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) << (STATE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;
  localparam logic [COEF_BITS-1:0]    B0_RST = COEF_BITS'(1) << COEF_FRAC_BITS;

  logic signed [COEF_BITS-1:0]   coef_r [NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic signed [ACC_W-1:0]       acc_nxt;
  logic signed [STATE_BITS-1:0]  s1_r;
  logic signed [STATE_BITS-1:0]  s2_r;
  logic                          hit_r;
  logic                          hit_nxt;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic                          clipped_r;

  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [ACC_W-1:0]       acc_sh;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          y_clip;
  logic signed [STATE_BITS-1:0]  s_sat;
  logic                          s_clip;

  assign in_req.ready       = cmd.in_ready;
  assign sts.in_valid       = in_req.valid;
  assign sts.out_free       = !out_valid_r || out_res.ready;
  assign out_res.valid      = out_valid_r;
  assign out_res.sample_out = sample_out_r;
  assign out_res.clipped    = clipped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[COEF_B0] <= B0_RST;
      coef_r[COEF_B1] <= '0;
      coef_r[COEF_B2] <= '0;
      coef_r[COEF_A1] <= '0;
      coef_r[COEF_A2] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_COEFS))) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    case (cmd.coef_sel)
      COEF_B0: mul_a = coef_r[COEF_B0];
      COEF_B1: mul_a = coef_r[COEF_B1];
      COEF_B2: mul_a = coef_r[COEF_B2];
      COEF_A1: mul_a = coef_r[COEF_A1];
      COEF_A2: mul_a = coef_r[COEF_A2];
      default: mul_a = '0;
    endcase
    mul_b = cmd.use_y ? y_r : x_r;
  end

  always_comb begin
    case (cmd.acc_op)
      ACC_OUT_SUM: acc_nxt = ACC_W'(prod_r) + ACC_W'(s1_r) + RND;
      ACC_S1_INIT: acc_nxt = ACC_W'(prod_r) + ACC_W'(s2_r);
      ACC_SUB:     acc_nxt = acc_r - ACC_W'(prod_r);
      ACC_LOAD:    acc_nxt = ACC_W'(prod_r);
      default:     acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    acc_sh = acc_r >>> COEF_FRAC_BITS;
    y_clip = 1'b1;
    if (acc_sh > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (acc_sh < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat  = acc_sh[SAMPLE_BITS-1:0];
      y_clip = 1'b0;
    end
    s_clip = 1'b1;
    if (acc_r > S_MAX) begin
      s_sat = S_MAX[STATE_BITS-1:0];
    end else if (acc_r < S_MIN) begin
      s_sat = S_MIN[STATE_BITS-1:0];
    end else begin
      s_sat  = acc_r[STATE_BITS-1:0];
      s_clip = 1'b0;
    end
  end

  assign hit_nxt = hit_r || (cmd.y_we && y_clip) || (cmd.s1_we && s_clip)
                   || (cmd.s2_we && s_clip);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (cmd.load) begin
      x_r <= in_req.sample_in;
    end
    if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (cmd.y_we) begin
      y_r <= y_sat;
    end
    if (cmd.out_we) begin
      sample_out_r <= y_r;
      clipped_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && in_req.clear_state) begin
        s1_r <= '0;
        s2_r <= '0;
      end else begin
        if (cmd.s1_we) begin
          s1_r <= s_sat;
        end
        if (cmd.s2_we) begin
          s2_r <= s_sat;
        end
      end
      hit_r <= cmd.load ? 1'b0 : hit_nxt;
      if (cmd.out_we) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BQ_ASSERT_IMP(a_out_room, cmd.out_we, !out_valid_r || out_res.ready, "result overwritten")
  `BQ_ASSERT_NXT(a_clear_states, cmd.load && in_req.clear_state, (s1_r == '0) && (s2_r == '0), "clear did not flush states")
  `BQ_ASSERT_NXT(a_result_shown, cmd.out_we, out_valid_r && (out_res.sample_out == $past(y_r)), "result not registered")

endmodule

// File: sv/biquad_iir_section_unit.sv
// Top level of the biquad IIR section (transposed direct form II).
// One request (signed sample plus clear flag) gives one result: the filtered
// sample, rounded half up and saturated, and a flag set when the output or a
// new 56-bit state saturated. The single shared coefficient multiplier forms
// the five products b0*x, b1*x, a1*y, b2*x, a2*y in that order, between
// accumulate and saturate steps; no new request is taken before the last
// one's result reaches the output register. A new request is accepted in the
// cycle the previous result is loaded, so a waiting result only stalls input
// when it is still held when the next one is done. Coefficients are signed
// Q7.24 at indexes b0, b1, b2, a1, a2 = 0..4; reset gives bypass (b0 = 1.0).
// Write them only while no request is in flight.
module biquad_iir_section_unit import bq_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_BITS-1:0] cfg_data,
  bq_in_if.sink                in_req,
  bq_out_if.source             out_res
);

  bq_cmd_t cmd;
  bq_sts_t sts;

  bq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  bq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .out_res   (out_res),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
